// ===== src/cca_pkg.sv =====
`default_nettype none

package cca_pkg;

    localparam int MODE_W    = 2;
    localparam int BYTES_W   = 23;
    localparam int CLUSTER_W = 10;
    localparam int STATUS_W  = 3;
    localparam int LENGTH_W  = 11;
    localparam int CFG_W     = 11;
    localparam int TAG_W     = 2;

    localparam int DEF_TABLE_DEPTH   = 1024;
    localparam int DEF_CLUSTER_BYTES = 4096;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    typedef logic [MODE_W-1:0]   t_mode;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [TAG_W-1:0]    t_tag;

    localparam t_mode MODE_FORMAT = 2'd0;
    localparam t_mode MODE_ALLOC  = 2'd1;
    localparam t_mode MODE_FOLLOW = 2'd2;
    localparam t_mode MODE_NOP    = 2'd3;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_NOSPACE = 3'd1;
    localparam t_status ST_END     = 3'd2;
    localparam t_status ST_RANGE   = 3'd3;
    localparam t_status ST_FREE    = 3'd4;

    localparam t_tag TAG_LINK = 2'd0;
    localparam t_tag TAG_END  = 2'd1;
    localparam t_tag TAG_FREE = 2'd2;

endpackage

`default_nettype wire

// ===== src/cluster_chain_allocator.sv =====
// Cluster chain allocator. Give a request with start while busy is low; the
// single result appears for exactly one cycle with o_strobe and cannot be held
// off, so the receiver must take it then. After reset the block is busy while it
// marks every table entry free; a format request repeats that sweep. Allocate makes
// up to two passes over the active entries through the one table read port: a
// counting pass that stops once the free entries found cover the byte length, then
// a linking pass. Follow reads the entry through S_FOLLOW_RD and S_FOLLOW_EV; an
// out-of-range cluster is answered straight from idle, without going busy.
// The configuration write channel is always ready; write it only while idle.
`default_nettype none

module cluster_chain_allocator #(
    parameter int TABLE_DEPTH   = cca_pkg::DEF_TABLE_DEPTH,
    parameter int CLUSTER_BYTES = cca_pkg::DEF_CLUSTER_BYTES
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [cca_pkg::MODE_W-1:0]       i_mode,
    input  wire  [cca_pkg::BYTES_W-1:0]      i_byte_length,
    input  wire  [cca_pkg::CLUSTER_W-1:0]    i_cluster_index,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [cca_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                             o_strobe,
    output logic [cca_pkg::STATUS_W-1:0]     o_status,
    output logic [cca_pkg::CLUSTER_W-1:0]    o_cluster_out,
    output logic [cca_pkg::LENGTH_W-1:0]     o_chain_length
);

    localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EW  = IW + cca_pkg::TAG_W;
    localparam int LW  = cca_pkg::LENGTH_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CLEAR     = 4'd1;
    localparam logic [3:0] S_COUNT     = 4'd4;
    localparam logic [3:0] S_LINK      = 4'd5;
    localparam logic [3:0] S_FINISH    = 4'd6;
    localparam logic [3:0] S_FOLLOW_RD = 4'd7;
    localparam logic [3:0] S_FOLLOW_EV = 4'd8;

    logic [EW-1:0] r_link_table [TABLE_DEPTH];
    logic [EW-1:0] r_rdata;

    logic [3:0]            r_state, n_state;
    logic                  r_fmt, n_fmt;
    logic [IW:0]           r_idx, n_idx;
    logic                  r_rd_vld, n_rd_vld;
    logic [cca_pkg::CFG_W-1:0] r_cfg;
    logic                  r_strobe, n_strobe;

    logic [IW-1:0]         r_rd_idx, n_rd_idx;
    logic [LW-1:0]         r_got, n_got;
    logic [LW-1:0]         r_need, n_need;
    logic [IW-1:0]         r_first, n_first;
    logic [IW-1:0]         r_prev, n_prev;
    logic                  r_have_prev, n_have_prev;
    logic [cca_pkg::BYTES_W-1:0] r_left, n_left;
    cca_pkg::t_status      r_status, n_status;
    logic [cca_pkg::CLUSTER_W-1:0] r_cluster, n_cluster;
    logic [LW-1:0]         r_len, n_len;

    logic [cca_pkg::CFG_W-1:0] w_count;
    logic                  w_issue;
    logic                  w_hit;
    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    logic [EW-1:0]         w_wdata;
    logic [31:0]           w_ci32;
    logic [31:0]           w_first32;
    logic [31:0]           w_link32;
    cca_pkg::t_tag         w_tag;

    always_comb begin
        if (32'(r_cfg) > 32'(TABLE_DEPTH)) begin
            w_count = cca_pkg::CFG_W'(TABLE_DEPTH);
        end else begin
            w_count = r_cfg;
        end
    end

    assign w_tag     = r_rdata[EW-1 -: cca_pkg::TAG_W];
    assign w_issue   = 32'(r_idx) < 32'(w_count);
    assign w_hit     = r_rd_vld && (w_tag == cca_pkg::TAG_FREE);
    assign w_ci32    = 32'(i_cluster_index);
    assign w_first32 = 32'(r_first);
    assign w_link32  = 32'(r_rdata[IW-1:0]);

    always_comb begin
        n_state     = r_state;
        n_fmt       = r_fmt;
        n_idx       = r_idx;
        n_rd_vld    = 1'b0;
        n_strobe    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_got       = r_got;
        n_need      = r_need;
        n_first     = r_first;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        n_left      = r_left;
        n_status    = r_status;
        n_cluster   = r_cluster;
        n_len       = r_len;
        w_we        = 1'b0;
        w_waddr     = r_idx[IW-1:0];
        w_wdata     = {cca_pkg::TAG_FREE, {IW{1'b0}}};

        unique case (r_state)
            S_IDLE: begin
                n_status  = cca_pkg::ST_OK;
                n_cluster = '0;
                n_len     = '0;
                n_idx     = '0;
                if (start) begin
                    unique case (i_mode)
                        cca_pkg::MODE_FORMAT: begin
                            n_fmt   = 1'b1;
                            n_state = S_CLEAR;
                        end
                        cca_pkg::MODE_ALLOC: begin
                            n_left      = i_byte_length;
                            n_got       = '0;
                            n_have_prev = 1'b0;
                            n_state     = S_COUNT;
                        end
                        cca_pkg::MODE_FOLLOW: begin
                            if (w_ci32 < 32'(w_count)) begin
                                n_idx   = w_ci32[IW:0];
                                n_state = S_FOLLOW_RD;
                            end else begin
                                n_status = cca_pkg::ST_RANGE;
                                n_strobe = 1'b1;
                            end
                        end
                        cca_pkg::MODE_NOP: begin
                            n_strobe = 1'b1;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                w_we  = 1'b1;
                n_idx = r_idx + 1'b1;
                if (32'(r_idx) == 32'(TABLE_DEPTH - 1)) begin
                    n_state  = S_IDLE;
                    n_strobe = r_fmt;
                    n_fmt    = 1'b0;
                end
            end
            S_COUNT: begin
                n_rd_vld = w_issue;
                n_rd_idx = r_idx[IW-1:0];
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (w_hit) begin
                    if (32'(r_left) <= 32'(CLUSTER_BYTES)) begin
                        n_need   = r_got + 1'b1;
                        n_got    = '0;
                        n_idx    = '0;
                        n_rd_vld = 1'b0;
                        n_state  = S_LINK;
                    end else begin
                        n_left = r_left - cca_pkg::BYTES_W'(CLUSTER_BYTES);
                        n_got  = r_got + 1'b1;
                    end
                end else if (!w_issue && !r_rd_vld) begin
                    n_status = cca_pkg::ST_NOSPACE;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_LINK: begin
                n_rd_vld = w_issue;
                n_rd_idx = r_idx[IW-1:0];
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (w_hit) begin
                    if (r_have_prev) begin
                        w_we    = 1'b1;
                        w_waddr = r_prev;
                        w_wdata = {cca_pkg::TAG_LINK, r_rd_idx};
                    end else begin
                        n_first = r_rd_idx;
                    end
                    n_prev      = r_rd_idx;
                    n_have_prev = 1'b1;
                    n_got       = r_got + 1'b1;
                    if (r_got + 1'b1 == r_need) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                w_we      = 1'b1;
                w_waddr   = r_prev;
                w_wdata   = {cca_pkg::TAG_END, {IW{1'b0}}};
                n_status  = cca_pkg::ST_OK;
                n_cluster = w_first32[cca_pkg::CLUSTER_W-1:0];
                n_len     = r_need;
                n_strobe  = 1'b1;
                n_state   = S_IDLE;
            end
            S_FOLLOW_RD: begin
                n_state = S_FOLLOW_EV;
            end
            S_FOLLOW_EV: begin
                unique case (w_tag)
                    cca_pkg::TAG_FREE: n_status = cca_pkg::ST_FREE;
                    cca_pkg::TAG_END:  n_status = cca_pkg::ST_END;
                    default: begin
                        n_status  = cca_pkg::ST_OK;
                        n_cluster = w_link32[cca_pkg::CLUSTER_W-1:0];
                    end
                endcase
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_link_table[w_waddr] <= w_wdata;
        end
        r_rdata <= r_link_table[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_fmt    <= 1'b0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
            r_cfg    <= cca_pkg::CFG_RESET;
        end else begin
            r_state  <= n_state;
            r_fmt    <= n_fmt;
            r_idx    <= n_idx;
            r_rd_vld <= n_rd_vld;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_got       <= n_got;
        r_need      <= n_need;
        r_first     <= n_first;
        r_prev      <= n_prev;
        r_have_prev <= n_have_prev;
        r_left      <= n_left;
        r_status    <= n_status;
        r_cluster   <= n_cluster;
        r_len       <= n_len;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_strobe       = r_strobe;
    assign o_status       = r_status;
    assign o_cluster_out  = r_cluster;
    assign o_chain_length = r_len;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted transfer neither started work nor answered");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != cca_pkg::ST_OK) |-> (o_chain_length == '0
            && o_cluster_out == '0))
        else $error("failed result carries a chain");

    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (32'(o_chain_length) <= 32'(w_count)))
        else $error("chain longer than active cluster count");

endmodule

`default_nettype wire

// ===== sim/cluster_chain_allocator_test.sv =====
`timescale 1ns / 1ps

module cluster_chain_allocator_test;

    localparam int TBL_DEPTH   = cca_pkg::DEF_TABLE_DEPTH;
    localparam int CL_BYTES    = cca_pkg::DEF_CLUSTER_BYTES;
    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_ITEMS = 46;

    localparam int MODE_W    = cca_pkg::MODE_W;
    localparam int BYTES_W   = cca_pkg::BYTES_W;
    localparam int CLUSTER_W = cca_pkg::CLUSTER_W;
    localparam int STATUS_W  = cca_pkg::STATUS_W;
    localparam int LENGTH_W  = cca_pkg::LENGTH_W;
    localparam int CFG_W     = cca_pkg::CFG_W;

    localparam logic [31:0] ENTRY_FREE = 32'hFFFF_FFFF;
    localparam logic [31:0] ENTRY_END  = 32'hCCCC_CCFF;

    typedef enum logic [1:0] {
        KIND_REQ,
        KIND_CFG,
        KIND_DRAIN
    } t_stim_kind;

    typedef struct packed {
        t_stim_kind             kind;
        cca_pkg::t_mode         mode;
        logic [BYTES_W-1:0]     nbytes;
        logic [CLUSTER_W-1:0]   idx;
        logic [CFG_W-1:0]       cfg;
    } t_stim_item;

    typedef struct packed {
        cca_pkg::t_status       status;
        logic [CLUSTER_W-1:0]   cluster;
        logic [LENGTH_W-1:0]    length;
    } t_chain_result;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [MODE_W-1:0]      i_mode = '0;
    logic [BYTES_W-1:0]     i_byte_length = '0;
    logic [CLUSTER_W-1:0]   i_cluster_index = '0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   o_strobe;
    logic [STATUS_W-1:0]    o_status;
    logic [CLUSTER_W-1:0]   o_cluster_out;
    logic [LENGTH_W-1:0]    o_chain_length;

    t_stim_item     pending_items[$];
    t_chain_result  expected_chains[$];
    logic [31:0]    link_table [TBL_DEPTH];
    logic [CFG_W-1:0] cfg_clusters = cca_pkg::CFG_RESET;

    int     items_sent = 0;
    int     sent_total = 0;
    int     results_seen = 0;
    int     err_count = 0;
    int     stall_cycles = 0;
    logic   stim_drained = 1'b0;

    cluster_chain_allocator #(
        .TABLE_DEPTH   (TBL_DEPTH),
        .CLUSTER_BYTES (CL_BYTES)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_byte_length   (i_byte_length),
        .i_cluster_index (i_cluster_index),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_cluster_out   (o_cluster_out),
        .o_chain_length  (o_chain_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic apply_request(input cca_pkg::t_mode mode,
                                 input logic [BYTES_W-1:0] nbytes,
                                 input logic [CLUSTER_W-1:0] idx,
                                 output t_chain_result res);
        int active;
        int need;
        int free_seen;
        int got;
        int prev;
        int i;
        logic [31:0] entry;
        res = '{status: cca_pkg::ST_OK, cluster: '0, length: '0};
        active = (int'(cfg_clusters) > TBL_DEPTH) ? TBL_DEPTH : int'(cfg_clusters);
        case (mode)
            cca_pkg::MODE_FORMAT: begin
                for (i = 0; i < TBL_DEPTH; i++)
                    link_table[i] = ENTRY_FREE;
            end
            cca_pkg::MODE_ALLOC: begin
                need = (int'(nbytes) + CL_BYTES - 1) / CL_BYTES;
                if (need == 0)
                    need = 1;
                free_seen = 0;
                for (i = 0; i < active; i++)
                    if (link_table[i] == ENTRY_FREE)
                        free_seen++;
                if (need > free_seen) begin
                    res.status = cca_pkg::ST_NOSPACE;
                end else begin
                    got  = 0;
                    prev = -1;
                    for (i = 0; i < active && got < need; i++) begin
                        if (link_table[i] == ENTRY_FREE) begin
                            if (prev >= 0)
                                link_table[prev] = i;
                            else
                                res.cluster = CLUSTER_W'(i);
                            prev = i;
                            got++;
                        end
                    end
                    link_table[prev] = ENTRY_END;
                    res.length = LENGTH_W'(need);
                end
            end
            cca_pkg::MODE_FOLLOW: begin
                if (int'(idx) >= active) begin
                    res.status = cca_pkg::ST_RANGE;
                end else begin
                    entry = link_table[idx];
                    if (entry == ENTRY_FREE) begin
                        res.status = cca_pkg::ST_FREE;
                    end else if (entry == ENTRY_END) begin
                        res.status = cca_pkg::ST_END;
                    end else begin
                        res.cluster = entry[CLUSTER_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic add_request(input cca_pkg::t_mode mode,
                               input logic [BYTES_W-1:0] nbytes,
                               input logic [CLUSTER_W-1:0] idx);
        t_stim_item item;
        item        = '0;
        item.kind   = KIND_REQ;
        item.mode   = mode;
        item.nbytes = (mode == cca_pkg::MODE_ALLOC) ? nbytes : BYTES_W'($urandom);
        item.idx    = (mode == cca_pkg::MODE_FOLLOW) ? idx : CLUSTER_W'($urandom);
        pending_items = {pending_items, item};
    endtask

    task automatic add_cfg(input logic [CFG_W-1:0] value);
        t_stim_item item;
        item      = '0;
        item.kind = KIND_CFG;
        item.cfg  = value;
        pending_items = {pending_items, item};
    endtask

    always @(posedge i_clk) begin : drive_proc
        t_chain_result res;
        t_stim_item    head;
        logic          hold_start;
        logic          hold_cfg;
        logic          settled;
        logic          idle_on;
        logic          next_start;
        logic          next_cfg;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            hold_start = start && busy;
            hold_cfg   = i_cfg_valid && !o_cfg_ready;
            if (start && !busy) begin
                apply_request(i_mode, i_byte_length, i_cluster_index, res);
                expected_chains = {expected_chains, res};
                items_sent++;
            end
            if (i_cfg_valid && o_cfg_ready)
                cfg_clusters = i_cfg_data;
            next_start = hold_start;
            next_cfg   = hold_cfg;
            settled    = (items_sent == results_seen) && !busy;
            idle_on    = (items_sent < 200) || (items_sent >= 330);
            if (!hold_start && !hold_cfg && pending_items.size() != 0
                && !(idle_on && $urandom_range(99) < 18)) begin
                head = pending_items[0];
                case (head.kind)
                    KIND_REQ: begin
                        next_start      = 1'b1;
                        i_mode          <= head.mode;
                        i_byte_length   <= head.nbytes;
                        i_cluster_index <= head.idx;
                        void'(pending_items.pop_front());
                    end
                    KIND_CFG: begin
                        if (settled) begin
                            next_cfg   = 1'b1;
                            i_cfg_data <= head.cfg;
                            void'(pending_items.pop_front());
                        end
                    end
                    default: begin
                        if (settled)
                            void'(pending_items.pop_front());
                    end
                endcase
            end
            start        <= next_start;
            i_cfg_valid  <= next_cfg;
            sent_total   <= items_sent;
            stim_drained <= (pending_items.size() == 0) && !next_start && !next_cfg;
        end
    end

    always @(posedge i_clk) begin : check_proc
        t_chain_result want;
        if (i_rst_n && o_strobe) begin
            results_seen <= results_seen + 1;
            if (expected_chains.size() == 0) begin
                err_count++;
                $display({"%0t: unexpected result, expected none, ",
                          "actual status %0d cluster %0d length %0d"},
                         $time, o_status, o_cluster_out, o_chain_length);
            end else begin
                want = expected_chains.pop_front();
                if (o_status !== want.status) begin
                    err_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_status);
                end
                if (o_cluster_out !== want.cluster) begin
                    err_count++;
                    $display("%0t: cluster_out mismatch, expected %0d, actual %0d",
                             $time, want.cluster, o_cluster_out);
                end
                if (o_chain_length !== want.length) begin
                    err_count++;
                    $display("%0t: chain_length mismatch, expected %0d, actual %0d",
                             $time, want.length, o_chain_length);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("cluster_chain_allocator regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase_counts[12] = '{1, 16, 1024, 2, 64, 2047, 7, 1000, 0, 33, 512, 5};
        int active;
        int kmax;
        int span;
        int pick;
        int k;
        int n;
        logic [BYTES_W-1:0]   nbytes;
        logic [CLUSTER_W-1:0] idx;
        t_stim_item           mark;

        foreach (link_table[i])
            link_table[i] = ENTRY_FREE;

        add_request(cca_pkg::MODE_FOLLOW, '0, 10'd0);
        add_request(cca_pkg::MODE_ALLOC, 23'd0, '0);
        add_request(cca_pkg::MODE_ALLOC, 23'd1, '0);
        add_request(cca_pkg::MODE_ALLOC, 23'd4096, '0);
        add_request(cca_pkg::MODE_ALLOC, 23'd4097, '0);
        add_request(cca_pkg::MODE_FOLLOW, '0, 10'd3);
        add_request(cca_pkg::MODE_FOLLOW, '0, 10'd4);
        add_request(cca_pkg::MODE_FOLLOW, '0, 10'd1023);
        add_request(cca_pkg::MODE_NOP, '0, '0);
        add_request(cca_pkg::MODE_ALLOC, 23'd4194304, '0);
        add_request(cca_pkg::MODE_ALLOC, 23'h7F_FFFF, '0);
        add_request(cca_pkg::MODE_FORMAT, '0, '0);
        add_request(cca_pkg::MODE_FOLLOW, '0, 10'd0);
        add_request(cca_pkg::MODE_ALLOC, 23'd4194304, '0);
        add_request(cca_pkg::MODE_FOLLOW, '0, 10'd1022);
        add_request(cca_pkg::MODE_FOLLOW, '0, 10'd1023);
        add_request(cca_pkg::MODE_ALLOC, 23'd0, '0);
        add_cfg(11'd4);
        add_request(cca_pkg::MODE_FOLLOW, '0, 10'd3);
        add_request(cca_pkg::MODE_FOLLOW, '0, 10'd4);
        add_request(cca_pkg::MODE_FOLLOW, '0, 10'd1023);
        add_request(cca_pkg::MODE_FORMAT, '0, '0);
        add_request(cca_pkg::MODE_ALLOC, 23'd16384, '0);
        add_request(cca_pkg::MODE_ALLOC, 23'd1, '0);
        add_cfg(11'd0);
        add_request(cca_pkg::MODE_ALLOC, 23'd0, '0);
        add_request(cca_pkg::MODE_FOLLOW, '0, 10'd0);
        add_cfg(11'd2047);
        add_request(cca_pkg::MODE_FOLLOW, '0, 10'd1023);
        add_request(cca_pkg::MODE_ALLOC, 23'd4194304, '0);

        foreach (phase_counts[p]) begin
            add_cfg(CFG_W'(phase_counts[p]));
            active = (phase_counts[p] > TBL_DEPTH) ? TBL_DEPTH : phase_counts[p];
            kmax   = (active == 0) ? 1 : ((active < 32) ? active : 32);
            span   = (active + 1 > TBL_DEPTH - 1) ? TBL_DEPTH - 1 : active + 1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    add_request(cca_pkg::MODE_FORMAT, '0, '0);
                end else if (pick < 50) begin
                    pick = $urandom_range(99);
                    if (pick < 10) begin
                        nbytes = BYTES_W'($urandom);
                    end else if (pick < 15) begin
                        nbytes = '0;
                    end else begin
                        k      = $urandom_range(kmax, 1);
                        nbytes = BYTES_W'((k - 1) * CL_BYTES + $urandom_range(CL_BYTES, 1));
                    end
                    add_request(cca_pkg::MODE_ALLOC, nbytes, '0);
                end else if (pick < 92) begin
                    pick = $urandom_range(99);
                    if (pick < 45)
                        idx = CLUSTER_W'($urandom_range((span < 63) ? span : 63));
                    else if (pick < 85)
                        idx = CLUSTER_W'($urandom_range(span));
                    else
                        idx = CLUSTER_W'($urandom);
                    add_request(cca_pkg::MODE_FOLLOW, '0, idx);
                end else begin
                    add_request(cca_pkg::MODE_NOP, '0, '0);
                end
                if (p == 3 && n == PHASE_ITEMS / 2) begin
                    mark      = '0;
                    mark.kind = KIND_DRAIN;
                    pending_items = {pending_items, mark};
                end
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (!(stim_drained && sent_total == results_seen));
        repeat (64) @(posedge i_clk);

        if (err_count == 0 && expected_chains.size() == 0) begin
            $display("cluster_chain_allocator regression: pass");
        end else begin
            $display("cluster_chain_allocator regression: fail");
        end
        $finish;
    end

endmodule

// ===== cluster_chain_allocator.f =====
src/cca_pkg.sv
src/cluster_chain_allocator.sv
sim/cluster_chain_allocator_test.sv
